### src/dmat_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Decimated moving average temperature: shared types and constants
// Field types, the sum width and the fixed-point scaling constants.
// ============================================================================
package dmat_pkg;

    localparam int CODE_W   = 10;
    localparam int TEMP_W   = 8;
    localparam int PERIOD_W = 8;
    localparam int SUM_W    = 12;

    typedef logic [CODE_W-1:0]   code_t;
    typedef logic [TEMP_W-1:0]   temp_t;
    typedef logic [PERIOD_W-1:0] period_t;
    typedef logic [SUM_W-1:0]    sum_t;

    localparam period_t PERIOD_RESET = 8'd10;

    // Degrees are code * 0.489, taken as (code * 512754) >> 20, exact for every code.
    localparam int SCALE_MULT_W = 19;
    localparam int SCALE_SHIFT  = 20;
    localparam int SCALE_PROD_W = CODE_W + SCALE_MULT_W;
    localparam int DEG_FULL_W   = SCALE_PROD_W - SCALE_SHIFT;
    localparam logic [SCALE_MULT_W-1:0] SCALE_MULT = 19'd512754;

    // The mean is sum * ceil(2^17 / WINDOW) >> 17, exact for any 12-bit sum.
    localparam int DIV_SHIFT  = 17;
    localparam int DIV_MULT_W = 17;
    localparam int DIV_PROD_W = SUM_W + DIV_MULT_W;

endpackage

### src/decimated_moving_average_temp.sv
`timescale 1ns / 1ps
// ============================================================================
// Decimated moving average temperature
// Every input transaction is one tick carrying a 10-bit converter code. Each
// time the tick counter reaches sample_period, the code is scaled to degrees
// (code * 0.489, saturated to 255) and stored in a ring of the last WINDOW
// samples; the truncated mean of the ring is the held average.
//
// Every input transaction produces exactly one output transaction carrying
// the held average and a flag telling whether this tick took a sample.
// The configuration channel writes sample_period; it is always ready and is
// meant to be written while no transaction is in flight.
// Throughput is one transaction per cycle while the receiver is ready. The
// pipeline has one stage for the scaling multiply, one for the ring RAM
// read, one for the running sum update and one for the mean multiply into
// the output register.
// The four stages move independently, so when the receiver stalls the block
// keeps accepting until the pipeline is full, then drops s_ready.
// Reset clears the counter, the running sum, the held average and the ring
// valid bits, so the ring reads as all zero and early means include zeros.
// ============================================================================
module decimated_moving_average_temp #(
    parameter int WINDOW = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  dmat_pkg::period_t cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  dmat_pkg::code_t   s_adc_code,
    output logic              m_valid,
    input  logic              m_ready,
    output dmat_pkg::temp_t   m_average_temp,
    output logic              m_sample_taken
);

    import dmat_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam logic [DIV_MULT_W-1:0] DIV_MULT =
        DIV_MULT_W'((2 ** DIV_SHIFT + WINDOW - 1) / WINDOW);
    localparam sum_t SUM_MAX = SUM_W'(255 * WINDOW);

    // Control state.
    period_t              sample_period_reg;
    period_t              tick_count_reg,  tick_count_next;
    logic [SLOT_W-1:0]    slot_reg,        slot_next;
    logic [WINDOW-1:0]    ring_valid_reg,  ring_valid_next;
    sum_t                 sum_reg,         sum_next;
    temp_t                held_reg,        held_next;
    logic                 s1_valid_reg,    s1_valid_next;
    logic                 s2_valid_reg,    s2_valid_next;
    logic                 s3_valid_reg,    s3_valid_next;
    logic                 m_valid_reg,     m_valid_next;

    // Stage payload.
    logic                    s1_hit_reg;
    logic [SLOT_W-1:0]       s1_slot_reg;
    logic [SCALE_PROD_W-1:0] s1_prod_reg;
    logic                    s2_hit_reg;
    logic [SLOT_W-1:0]       s2_slot_reg;
    temp_t                   s2_deg_reg;
    logic                    s2_old_valid_reg;
    logic                    s3_hit_reg;
    sum_t                    s3_sum_reg;
    temp_t                   m_average_temp_reg;
    logic                    m_sample_taken_reg;

    logic                    tick_hit;
    logic                    s1_load, s2_load, s3_load, out_load;
    logic                    s1_ready, s2_ready, s3_ready, out_ready;
    logic [DEG_FULL_W-1:0]   deg_full;
    temp_t                   deg;
    temp_t                   ring_rd_data;
    temp_t                   old_sample;
    logic [DIV_PROD_W-1:0]   mean_prod;
    temp_t                   mean;

    // Stage handshakes.
    assign out_ready = !m_valid_reg || m_ready;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_ready   = s1_ready;
    assign cfg_ready = 1'b1;

    assign s1_load  = s_valid && s1_ready;
    assign s2_load  = s1_valid_reg && s2_ready;
    assign s3_load  = s2_valid_reg && s3_ready;
    assign out_load = s3_valid_reg && out_ready;

    // Tick counting and slot selection at acceptance.
    assign tick_hit = (tick_count_reg + 8'd1) == sample_period_reg;

    always_comb begin
        tick_count_next = tick_count_reg;
        slot_next       = slot_reg;
        if (s1_load) begin
            tick_count_next = tick_hit ? '0 : tick_count_reg + 8'd1;
            if (tick_hit) begin
                slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            end
        end
    end

    // Scaling and saturation.
    assign deg_full = s1_prod_reg[SCALE_SHIFT +: DEG_FULL_W];
    assign deg      = deg_full[DEG_FULL_W-1] ? '1 : deg_full[TEMP_W-1:0];

    // Ring read-modify-write: read when entering stage 2, write when leaving it.
    dmat_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (s3_load && s2_hit_reg),
        .wr_addr (s2_slot_reg),
        .wr_data (s2_deg_reg),
        .rd_en   (s2_load),
        .rd_addr (s1_slot_reg),
        .rd_data (ring_rd_data)
    );

    assign old_sample = s2_old_valid_reg ? ring_rd_data : '0;

    always_comb begin
        ring_valid_next = ring_valid_reg;
        sum_next        = sum_reg;
        if (s3_load && s2_hit_reg) begin
            ring_valid_next[s2_slot_reg] = 1'b1;
            sum_next = sum_reg - sum_t'(old_sample) + sum_t'(s2_deg_reg);
        end
    end

    // Mean of the ring.
    assign mean_prod = DIV_PROD_W'(s3_sum_reg) * DIV_PROD_W'(DIV_MULT);
    assign mean      = mean_prod[DIV_SHIFT +: TEMP_W];

    always_comb begin
        held_next = held_reg;
        if (out_load && s3_hit_reg) begin
            held_next = mean;
        end
    end

    // Stage occupancy.
    always_comb begin
        s1_valid_next = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_reg);
        s2_valid_next = s2_load ? 1'b1 : (s3_load ? 1'b0 : s2_valid_reg);
        s3_valid_next = s3_load ? 1'b1 : (out_load ? 1'b0 : s3_valid_reg);
        m_valid_next  = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_period_reg <= PERIOD_RESET;
            tick_count_reg    <= '0;
            slot_reg          <= '0;
            ring_valid_reg    <= '0;
            sum_reg           <= '0;
            held_reg          <= '0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            s3_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                sample_period_reg <= cfg_data;
            end
            tick_count_reg <= tick_count_next;
            slot_reg       <= slot_next;
            ring_valid_reg <= ring_valid_next;
            sum_reg        <= sum_next;
            held_reg       <= held_next;
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            s3_valid_reg   <= s3_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_hit_reg  <= tick_hit;
            s1_slot_reg <= slot_reg;
            s1_prod_reg <= SCALE_PROD_W'(s_adc_code) * SCALE_PROD_W'(SCALE_MULT);
        end
        if (s2_load) begin
            s2_hit_reg       <= s1_hit_reg;
            s2_slot_reg      <= s1_slot_reg;
            s2_deg_reg       <= deg;
            s2_old_valid_reg <= ring_valid_reg[s1_slot_reg];
        end
        if (s3_load) begin
            s3_hit_reg <= s2_hit_reg;
            s3_sum_reg <= sum_next;
        end
        if (out_load) begin
            m_average_temp_reg <= s3_hit_reg ? mean : held_reg;
            m_sample_taken_reg <= s3_hit_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_average_temp = m_average_temp_reg;
    assign m_sample_taken = m_sample_taken_reg;

    // A ring entry is never read in the same cycle as it is written.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_load && s2_hit_reg && s2_load) |-> (s1_slot_reg != s2_slot_reg))
        else $error("ring read and write collide on one entry");

    // The running sum never exceeds a full ring of saturated samples.
    assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg <= SUM_MAX)
        else $error("running sum out of range");

    // The write slot stays inside the window.
    assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_W'(WINDOW - 1))
        else $error("write slot beyond window");

    // A sampling tick restarts the tick counter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_load && tick_hit) |=> (tick_count_reg == '0))
        else $error("tick counter not cleared after sample");

endmodule

### src/dmat_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// Decimated moving average temperature: sample RAM
// Simple dual-port RAM with one write port and a registered read port.
// ============================================================================
module dmat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
